// ----- rtl/core/sce_pkg.sv -----
// ----------------------------------------------------------------------------
// sce_pkg
// types, sizes and codes shared by the seam carving engine
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int SEAM_DEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int IDX_W  = $clog2(SEAM_DEPTH);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIM_W  = 9;
    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int COST_W = 18;
    localparam int SQ_W   = 20;
    localparam int ROOT_W = SQ_W / 2;
    localparam int ACC_W  = 19;

    localparam logic [COST_W-1:0] COST_MAX = '1;
    localparam logic [DIM_W-1:0]  DIM_MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]  DIM_MAX_H = DIM_W'(MAX_HEIGHT);

    localparam logic [2:0] REQ_BEGIN     = 3'd0;
    localparam logic [2:0] REQ_WRITE_PIX = 3'd1;
    localparam logic [2:0] REQ_FIND      = 3'd2;
    localparam logic [2:0] REQ_READ_SEAM = 3'd3;
    localparam logic [2:0] REQ_REMOVE    = 3'd4;
    localparam logic [2:0] REQ_READ_PIX  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [1:0] ST_NO_SEAM  = 2'd2;
    localparam logic [1:0] ST_DIM_ONE  = 2'd3;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DIRECTION    = 2'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] pixel_row;
        logic [7:0] pixel_col;
        logic [7:0] seam_step;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        red_out;
        logic [7:0]        green_out;
        logic [7:0]        blue_out;
        logic [7:0]        seam_position;
        logic [COST_W-1:0] seam_cost;
        logic [DIM_W-1:0]  width_now;
        logic [DIM_W-1:0]  height_now;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PIX_RD,
        S_SEAM_RD,
        S_E_RD,
        S_E_SQ,
        S_E_ROOT,
        S_E_WAIT,
        S_D_RD,
        S_D_WR,
        S_M_RD,
        S_M_CMP,
        S_M_END,
        S_B_RD,
        S_B_SEL,
        S_R_SEAM,
        S_R_LOAD,
        S_R_MOVE,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/sce_if.sv -----
// ----------------------------------------------------------------------------
// sce interfaces
// request, response and configuration channels of the seam carving engine
// ----------------------------------------------------------------------------
`default_nettype none

interface sce_req_if import sce_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sce_rsp_if import sce_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sce_cfg_if import sce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       index;
    logic [DIM_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sce_ram.sv -----
// ----------------------------------------------------------------------------
// sce_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/sce_isqrt.sv -----
// ----------------------------------------------------------------------------
// sce_isqrt
// iterative floor square root, two bits of the radicand per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sce_isqrt import sce_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ACC_W-1:0]  value,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);

    logic [SQ_W-1:0] n_reg, n_next;
    logic [SQ_W-1:0] res_reg, res_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SQ_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = SQ_W'(value);
            res_next  = '0;
            bit_next  = SQ_W'(1) << (SQ_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/seam_carving_engine_top.sv -----
// ----------------------------------------------------------------------------
// seam_carving_engine_top
// rgb frame store with dual-gradient energy, seam search and seam removal
// ----------------------------------------------------------------------------
// channels: cfg writes frame_width, frame_height and seam_direction by index;
// req carries one request beat, rsp returns exactly one result beat for it.
// one request is worked on at a time; req is ready only while the sequencer
// is idle, and a new beat is taken while the previous result still waits.
// find seam walks the frame through the pixel and cost memories: energy for
// every active pixel (4 pixel reads, 6 squaring steps through one squarer,
// 10 square-root steps), then the cost accumulation over each cell, a scan of
// the last line and one backtracking step per line.
// remove seam reads each line's seam entry and moves every pixel behind it
// back by one place, with a read and then a write per pixel shifted.
// reset: active size 256 x 256, no valid seam, seam cost 0; memory contents
// are undefined until written. a stalled rsp holds its beat and the block
// finishes the next request up to the point of delivering it.
// ----------------------------------------------------------------------------
`default_nettype none

module seam_carving_engine_top import sce_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sce_cfg_if.sink    cfg,
    sce_req_if.sink    req,
    sce_rsp_if.source  rsp
);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  t_reg, t_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  m_reg, m_next;
    logic [2:0]        ph_reg, ph_next;
    logic [PIX_W-1:0]  nb_reg [4];
    logic [PIX_W-1:0]  nb_next [4];
    logic [COST_W-1:0] cv_reg [4];
    logic [COST_W-1:0] cv_next [4];
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [COST_W-1:0] best_reg, best_next;
    logic [1:0]        status_reg, status_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [7:0]        pos_reg, pos_next;
    logic [DIM_W-1:0]  act_w_reg, act_w_next;
    logic [DIM_W-1:0]  act_h_reg, act_h_next;
    logic              seam_valid_reg, seam_valid_next;
    logic [COST_W-1:0] seam_total_reg, seam_total_next;
    logic [DIM_W-1:0]  fw_reg, fw_next;
    logic [DIM_W-1:0]  fh_reg, fh_next;
    logic              dir_reg, dir_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    logic              pix_we;
    logic [ADDR_W-1:0] pix_waddr, pix_raddr;
    logic [PIX_W-1:0]  pix_wdata, pix_rdata;
    logic              cost_we;
    logic [ADDR_W-1:0] cost_waddr, cost_raddr;
    logic [COST_W-1:0] cost_wdata, cost_rdata;
    logic              seam_we;
    logic [IDX_W-1:0]  seam_waddr, seam_raddr;
    logic [7:0]        seam_wdata, seam_rdata;

    logic              sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;

    logic [DIM_W-1:0]  len_l, len_k;
    logic [DIM_W-1:0]  t_p1, k_p1, m_p1;
    logic              req_fire, cfg_fire, out_free;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic dir,
                                                    input logic [IDX_W-1:0] t,
                                                    input logic [IDX_W-1:0] k);
        logic [ADDR_W-1:0] a;
        if (dir)
        begin
            a = {k[ROW_W-1:0], t[COL_W-1:0]};
        end
        else
        begin
            a = {t[ROW_W-1:0], k[COL_W-1:0]};
        end
        return a;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    sce_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    sce_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    sce_ram #(.WIDTH(8), .DEPTH(SEAM_DEPTH)) u_seam_ram (
        .clk   (clk),
        .we    (seam_we),
        .waddr (seam_waddr),
        .wdata (seam_wdata),
        .raddr (seam_raddr),
        .rdata (seam_rdata)
    );

    sce_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (acc_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign req.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;
    assign req_fire   = req.valid && req.ready;
    assign cfg_fire   = cfg.valid && cfg.ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    assign len_l = dir_reg ? act_w_reg : act_h_reg;
    assign len_k = dir_reg ? act_h_reg : act_w_reg;
    assign t_p1  = {1'b0, t_reg} + DIM_W'(1);
    assign k_p1  = {1'b0, k_reg} + DIM_W'(1);
    assign m_p1  = {1'b0, m_reg} + DIM_W'(1);

    always_comb
    begin
        logic [CH_W-1:0]   opa, opb, dif;
        logic [2*CH_W-1:0] sq;
        logic [COST_W-1:0] mn;
        logic [COST_W:0]   sum;
        logic              has_a, has_c;
        logic [IDX_W-1:0]  m_new;
        logic [IDX_W-1:0]  r_dn, r_up, c_rt, c_lf;

        state_next      = state_reg;
        t_next          = t_reg;
        k_next          = k_reg;
        m_next          = m_reg;
        ph_next         = ph_reg;
        nb_next         = nb_reg;
        cv_next         = cv_reg;
        acc_next        = acc_reg;
        best_next       = best_reg;
        status_next     = status_reg;
        pix_next        = pix_reg;
        pos_next        = pos_reg;
        act_w_next      = act_w_reg;
        act_h_next      = act_h_reg;
        seam_valid_next = seam_valid_reg;
        seam_total_next = seam_total_reg;
        fw_next         = fw_reg;
        fh_next         = fh_reg;
        dir_next        = dir_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        pix_we     = 1'b0;
        pix_waddr  = '0;
        pix_wdata  = '0;
        pix_raddr  = '0;
        cost_we    = 1'b0;
        cost_waddr = '0;
        cost_wdata = '0;
        cost_raddr = '0;
        seam_we    = 1'b0;
        seam_waddr = '0;
        seam_wdata = '0;
        seam_raddr = '0;
        sq_start   = 1'b0;

        opa   = '0;
        opb   = '0;
        dif   = '0;
        sq    = '0;
        mn    = '0;
        sum   = '0;
        has_a = 1'b0;
        has_c = 1'b0;
        m_new = m_reg;
        r_dn  = (t_p1 < act_h_reg) ? t_p1[IDX_W-1:0] : t_reg;
        r_up  = (t_reg != '0) ? t_reg - IDX_W'(1) : t_reg;
        c_rt  = (k_p1 < act_w_reg) ? k_p1[IDX_W-1:0] : k_reg;
        c_lf  = (k_reg != '0) ? k_reg - IDX_W'(1) : k_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_fire)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH:  fw_next = cfg.data;
                CFG_FRAME_HEIGHT: fh_next = cfg.data;
                CFG_DIRECTION:
                begin
                    dir_next        = cfg.data[0];
                    seam_valid_next = 1'b0;
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    status_next = ST_OK;
                    pix_next    = '0;
                    pos_next    = '0;
                    state_next  = S_RESP;
                    t_next      = '0;
                    k_next      = '0;
                    ph_next     = '0;
                    case (req.data.req_type)
                        REQ_BEGIN:
                        begin
                            act_w_next      = clamp_dim(fw_reg, DIM_MAX_W);
                            act_h_next      = clamp_dim(fh_reg, DIM_MAX_H);
                            seam_valid_next = 1'b0;
                        end
                        REQ_WRITE_PIX:
                        begin
                            if ({1'b0, req.data.pixel_row} < act_h_reg &&
                                {1'b0, req.data.pixel_col} < act_w_reg)
                            begin
                                pix_we    = 1'b1;
                                pix_waddr = {req.data.pixel_row[ROW_W-1:0],
                                             req.data.pixel_col[COL_W-1:0]};
                                pix_wdata = {req.data.red_in, req.data.green_in,
                                             req.data.blue_in};
                            end
                            else
                            begin
                                status_next = ST_OUTSIDE;
                            end
                        end
                        REQ_FIND:
                        begin
                            state_next = S_E_RD;
                        end
                        REQ_READ_SEAM:
                        begin
                            if (!seam_valid_reg)
                            begin
                                status_next = ST_NO_SEAM;
                            end
                            else if ({1'b0, req.data.seam_step} >= len_l)
                            begin
                                status_next = ST_OUTSIDE;
                            end
                            else
                            begin
                                seam_raddr = req.data.seam_step[IDX_W-1:0];
                                state_next = S_SEAM_RD;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (!seam_valid_reg)
                            begin
                                status_next = ST_NO_SEAM;
                            end
                            else if (len_k <= DIM_W'(1))
                            begin
                                status_next = ST_DIM_ONE;
                            end
                            else
                            begin
                                state_next = S_R_SEAM;
                            end
                        end
                        REQ_READ_PIX:
                        begin
                            if ({1'b0, req.data.pixel_row} < act_h_reg &&
                                {1'b0, req.data.pixel_col} < act_w_reg)
                            begin
                                pix_raddr  = {req.data.pixel_row[ROW_W-1:0],
                                              req.data.pixel_col[COL_W-1:0]};
                                state_next = S_PIX_RD;
                            end
                            else
                            begin
                                status_next = ST_OUTSIDE;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_PIX_RD:
            begin
                pix_next   = pix_rdata;
                state_next = S_RESP;
            end

            S_SEAM_RD:
            begin
                pos_next   = seam_rdata;
                state_next = S_RESP;
            end

            // energy: neighbours down, up, right, left
            S_E_RD:
            begin
                case (ph_reg)
                    3'd0: pix_raddr = {r_dn[ROW_W-1:0], k_reg[COL_W-1:0]};
                    3'd1: pix_raddr = {r_up[ROW_W-1:0], k_reg[COL_W-1:0]};
                    3'd2: pix_raddr = {t_reg[ROW_W-1:0], c_rt[COL_W-1:0]};
                    3'd3: pix_raddr = {t_reg[ROW_W-1:0], c_lf[COL_W-1:0]};
                    default: pix_raddr = '0;
                endcase
                case (ph_reg)
                    3'd1: nb_next[0] = pix_rdata;
                    3'd2: nb_next[1] = pix_rdata;
                    3'd3: nb_next[2] = pix_rdata;
                    3'd4: nb_next[3] = pix_rdata;
                    default: ;
                endcase
                if (ph_reg == 3'd4)
                begin
                    ph_next    = '0;
                    acc_next   = '0;
                    state_next = S_E_SQ;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end

            S_E_SQ:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        opa = nb_reg[2][23:16];
                        opb = nb_reg[3][23:16];
                    end
                    3'd1:
                    begin
                        opa = nb_reg[2][15:8];
                        opb = nb_reg[3][15:8];
                    end
                    3'd2:
                    begin
                        opa = nb_reg[2][7:0];
                        opb = nb_reg[3][7:0];
                    end
                    3'd3:
                    begin
                        opa = nb_reg[0][23:16];
                        opb = nb_reg[1][23:16];
                    end
                    3'd4:
                    begin
                        opa = nb_reg[0][15:8];
                        opb = nb_reg[1][15:8];
                    end
                    default:
                    begin
                        opa = nb_reg[0][7:0];
                        opb = nb_reg[1][7:0];
                    end
                endcase
                dif      = (opa > opb) ? opa - opb : opb - opa;
                sq       = dif * dif;
                acc_next = acc_reg + ACC_W'(sq);
                if (ph_reg == 3'd5)
                begin
                    state_next = S_E_ROOT;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end

            S_E_ROOT:
            begin
                sq_start   = 1'b1;
                state_next = S_E_WAIT;
            end

            S_E_WAIT:
            begin
                if (sq_done)
                begin
                    cost_we    = 1'b1;
                    cost_waddr = {t_reg[ROW_W-1:0], k_reg[COL_W-1:0]};
                    cost_wdata = COST_W'(sq_root);
                    ph_next    = '0;
                    state_next = S_E_RD;
                    if (k_p1 < act_w_reg)
                    begin
                        k_next = k_p1[IDX_W-1:0];
                    end
                    else
                    begin
                        k_next = '0;
                        if (t_p1 < act_h_reg)
                        begin
                            t_next = t_p1[IDX_W-1:0];
                        end
                        else if (len_l > DIM_W'(1))
                        begin
                            t_next     = IDX_W'(1);
                            state_next = S_D_RD;
                        end
                        else
                        begin
                            t_next     = '0;
                            state_next = S_M_RD;
                        end
                    end
                end
            end

            // accumulation: previous line centre, lower, upper, then own cell
            S_D_RD:
            begin
                case (ph_reg)
                    3'd0: cost_raddr = cell_addr(dir_reg, t_reg - IDX_W'(1), k_reg);
                    3'd1: cost_raddr = cell_addr(dir_reg, t_reg - IDX_W'(1), c_lf);
                    3'd2: cost_raddr = cell_addr(dir_reg, t_reg - IDX_W'(1),
                                                 (k_p1 < len_k) ? k_p1[IDX_W-1:0] : k_reg);
                    3'd3: cost_raddr = cell_addr(dir_reg, t_reg, k_reg);
                    default: cost_raddr = '0;
                endcase
                case (ph_reg)
                    3'd1: cv_next[0] = cost_rdata;
                    3'd2: cv_next[1] = cost_rdata;
                    3'd3: cv_next[2] = cost_rdata;
                    3'd4: cv_next[3] = cost_rdata;
                    default: ;
                endcase
                if (ph_reg == 3'd4)
                begin
                    ph_next    = '0;
                    state_next = S_D_WR;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end

            S_D_WR:
            begin
                mn = cv_reg[0];
                if (cv_reg[1] < mn)
                begin
                    mn = cv_reg[1];
                end
                if (cv_reg[2] < mn)
                begin
                    mn = cv_reg[2];
                end
                sum        = {1'b0, cv_reg[3]} + {1'b0, mn};
                cost_we    = 1'b1;
                cost_waddr = cell_addr(dir_reg, t_reg, k_reg);
                cost_wdata = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
                state_next = S_D_RD;
                if (k_p1 < len_k)
                begin
                    k_next = k_p1[IDX_W-1:0];
                end
                else
                begin
                    k_next = '0;
                    if (t_p1 < len_l)
                    begin
                        t_next = t_p1[IDX_W-1:0];
                    end
                    else
                    begin
                        state_next = S_M_RD;
                    end
                end
            end

            // cheapest cell of the last line, first of equal minima
            S_M_RD:
            begin
                cost_raddr = cell_addr(dir_reg, t_reg, k_reg);
                state_next = S_M_CMP;
            end

            S_M_CMP:
            begin
                if (k_reg == '0 || cost_rdata < best_reg)
                begin
                    best_next = cost_rdata;
                    m_next    = k_reg;
                end
                if (k_p1 < len_k)
                begin
                    k_next     = k_p1[IDX_W-1:0];
                    state_next = S_M_RD;
                end
                else
                begin
                    state_next = S_M_END;
                end
            end

            S_M_END:
            begin
                seam_total_next = best_reg;
                seam_we         = 1'b1;
                seam_waddr      = t_reg;
                seam_wdata      = 8'(m_reg);
                ph_next         = '0;
                if (t_reg == '0)
                begin
                    seam_valid_next = 1'b1;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_B_RD;
                end
            end

            // backtracking: straight, lower, upper neighbour on the line before
            S_B_RD:
            begin
                case (ph_reg)
                    3'd0: cost_raddr = cell_addr(dir_reg, t_reg - IDX_W'(1), m_reg);
                    3'd1: cost_raddr = cell_addr(dir_reg, t_reg - IDX_W'(1),
                                                 (m_reg != '0) ? m_reg - IDX_W'(1) : m_reg);
                    3'd2: cost_raddr = cell_addr(dir_reg, t_reg - IDX_W'(1),
                                                 (m_p1 < len_k) ? m_p1[IDX_W-1:0] : m_reg);
                    default: cost_raddr = '0;
                endcase
                case (ph_reg)
                    3'd1: cv_next[0] = cost_rdata;
                    3'd2: cv_next[1] = cost_rdata;
                    3'd3: cv_next[2] = cost_rdata;
                    default: ;
                endcase
                if (ph_reg == 3'd3)
                begin
                    ph_next    = '0;
                    state_next = S_B_SEL;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end

            S_B_SEL:
            begin
                has_a = (m_reg != '0);
                has_c = (m_p1 < len_k);
                mn    = cv_reg[0];
                if (has_a && cv_reg[1] < mn)
                begin
                    mn = cv_reg[1];
                end
                if (has_c && cv_reg[2] < mn)
                begin
                    mn = cv_reg[2];
                end
                if (has_a && cv_reg[1] == mn)
                begin
                    m_new = m_reg - IDX_W'(1);
                end
                else if (has_c && cv_reg[2] == mn)
                begin
                    m_new = m_p1[IDX_W-1:0];
                end
                m_next     = m_new;
                t_next     = t_reg - IDX_W'(1);
                seam_we    = 1'b1;
                seam_waddr = t_reg - IDX_W'(1);
                seam_wdata = 8'(m_new);
                if (t_reg == IDX_W'(1))
                begin
                    seam_valid_next = 1'b1;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_B_RD;
                end
            end

            // removal: shift each line's cells past its seam entry back by one place
            S_R_SEAM:
            begin
                seam_raddr = t_reg;
                state_next = S_R_LOAD;
            end

            S_R_LOAD:
            begin
                k_next     = seam_rdata[IDX_W-1:0];
                ph_next    = '0;
                state_next = S_R_MOVE;
            end

            S_R_MOVE:
            begin
                if (k_p1 < len_k)
                begin
                    if (ph_reg == '0)
                    begin
                        pix_raddr = cell_addr(dir_reg, t_reg, k_p1[IDX_W-1:0]);
                        ph_next   = 3'd1;
                    end
                    else
                    begin
                        pix_we    = 1'b1;
                        pix_waddr = cell_addr(dir_reg, t_reg, k_reg);
                        pix_wdata = pix_rdata;
                        k_next    = k_p1[IDX_W-1:0];
                        ph_next   = '0;
                    end
                end
                else if (t_p1 < len_l)
                begin
                    t_next     = t_p1[IDX_W-1:0];
                    state_next = S_R_SEAM;
                end
                else
                begin
                    if (dir_reg)
                    begin
                        act_h_next = act_h_reg - DIM_W'(1);
                    end
                    else
                    begin
                        act_w_next = act_w_reg - DIM_W'(1);
                    end
                    seam_valid_next = 1'b0;
                    state_next      = S_RESP;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.red_out       = pix_reg[23:16];
                    out_data_next.green_out     = pix_reg[15:8];
                    out_data_next.blue_out      = pix_reg[7:0];
                    out_data_next.seam_position = pos_reg;
                    out_data_next.seam_cost     = seam_total_reg;
                    out_data_next.width_now     = act_w_reg;
                    out_data_next.height_now    = act_h_reg;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_w_reg      <= DIM_MAX_W;
            act_h_reg      <= DIM_MAX_H;
            seam_valid_reg <= 1'b0;
            seam_total_reg <= '0;
            fw_reg         <= DIM_W'(256);
            fh_reg         <= DIM_W'(256);
            dir_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            act_w_reg      <= act_w_next;
            act_h_reg      <= act_h_next;
            seam_valid_reg <= seam_valid_next;
            seam_total_reg <= seam_total_next;
            fw_reg         <= fw_next;
            fh_reg         <= fh_next;
            dir_reg        <= dir_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        k_reg        <= k_next;
        m_reg        <= m_next;
        ph_reg       <= ph_next;
        nb_reg       <= nb_next;
        cv_reg       <= cv_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
        pix_reg      <= pix_next;
        pos_reg      <= pos_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
